### hdl/reusable_id_allocator_unit_macros.svh
// assertion macros for the reusable id allocator
// no dependencies; included by the top level only
`ifndef REUSABLE_ID_ALLOCATOR_UNIT_MACROS_SVH
`define REUSABLE_ID_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RIA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("id allocator check failed");

// next-cycle implication, disabled during reset
`define RIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("id allocator check failed");

`endif

### hdl/ria_pkg.sv
// shared types and constants of the reusable id allocator
// no dependencies; used by ria_find and reusable_id_allocator_unit
`timescale 1ns / 1ps
`default_nettype none

package ria_pkg;

   localparam int ID_W       = 8;
   localparam int MAP_DEPTH  = 1 << ID_W;
   localparam int ID_COUNT   = 256;
   localparam int SPACE_SIZE = (ID_COUNT < MAP_DEPTH) ? ID_COUNT : MAP_DEPTH;
   localparam int SPACE_TOP  = SPACE_SIZE - 1;

   localparam int GRP_IDX_W  = ID_W / 2;
   localparam int BIT_IDX_W  = ID_W - GRP_IDX_W;
   localparam int GRP_W      = 1 << BIT_IDX_W;
   localparam int GRP_N      = 1 << GRP_IDX_W;

   typedef logic [ID_W-1:0]      id_type;
   typedef logic [MAP_DEPTH-1:0] map_type;
   typedef logic [GRP_IDX_W-1:0] grp_idx_type;
   typedef logic [BIT_IDX_W-1:0] bit_idx_type;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_CLAIM   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TAKEN     = 2'd1,
      ST_EXHAUSTED = 2'd2,
      ST_INVALID   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0] operation;
      id_type     request_id;
   } req_type;

   typedef struct packed {
      id_type     granted_id;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic   free_found;
      id_type free_low;
      logic   top_found;
      id_type top_high;
   } search_type;

endpackage

`default_nettype wire

### hdl/ria_find.sv
// two-level priority search over the id bitmaps: lowest freed id, highest assigned id
// depends on ria_pkg
`timescale 1ns / 1ps
`default_nettype none

module ria_find (
   input  var ria_pkg::map_type    freed_map,
   input  var ria_pkg::map_type    assigned_map,
   output ria_pkg::search_type     search
);

   logic [ria_pkg::GRP_N-1:0] free_grp_any;
   logic [ria_pkg::GRP_N-1:0] asg_grp_any;
   ria_pkg::grp_idx_type      free_grp;
   ria_pkg::grp_idx_type      asg_grp;
   logic [ria_pkg::GRP_W-1:0] free_word;
   logic [ria_pkg::GRP_W-1:0] asg_word;
   ria_pkg::bit_idx_type      free_bit;
   ria_pkg::bit_idx_type      asg_bit;

   // per-group summaries
   always_comb begin
      for (int g = 0; g < ria_pkg::GRP_N; g++) begin
         free_grp_any[g] = |freed_map[g*ria_pkg::GRP_W +: ria_pkg::GRP_W];
         asg_grp_any[g]  = |assigned_map[g*ria_pkg::GRP_W +: ria_pkg::GRP_W];
      end
   end

   // group select
   always_comb begin
      free_grp = '0;
      asg_grp  = '0;
      for (int g = ria_pkg::GRP_N - 1; g >= 0; g--) begin
         if (free_grp_any[g]) begin
            free_grp = ria_pkg::grp_idx_type'(g);
         end
      end
      for (int g = 0; g < ria_pkg::GRP_N; g++) begin
         if (asg_grp_any[g]) begin
            asg_grp = ria_pkg::grp_idx_type'(g);
         end
      end
   end

   assign free_word = freed_map[free_grp*ria_pkg::GRP_W +: ria_pkg::GRP_W];
   assign asg_word  = assigned_map[asg_grp*ria_pkg::GRP_W +: ria_pkg::GRP_W];

   // bit select within the chosen group
   always_comb begin
      free_bit = '0;
      asg_bit  = '0;
      for (int b = ria_pkg::GRP_W - 1; b >= 0; b--) begin
         if (free_word[b]) begin
            free_bit = ria_pkg::bit_idx_type'(b);
         end
      end
      for (int b = 0; b < ria_pkg::GRP_W; b++) begin
         if (asg_word[b]) begin
            asg_bit = ria_pkg::bit_idx_type'(b);
         end
      end
   end

   always_comb begin
      search.free_found = |free_grp_any;
      search.free_low   = {free_grp, free_bit};
      search.top_found  = |asg_grp_any;
      search.top_high   = (|asg_grp_any) ? {asg_grp, asg_bit} : '0;
   end

endmodule

`default_nettype wire

### hdl/reusable_id_allocator_unit.sv
// reusable id allocator: assigned and freed bitmaps with allocate, claim and release
// depends on ria_pkg, ria_find and reusable_id_allocator_unit_macros.svh
//
// usage
//   req channel (req_valid/req_ready/req_data) carries one request per transfer:
//   operation (allocate, claim, release) and request_id.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one result per
//   request, in request order: granted_id and status.
//   a request accepted into the input register moves on into the result
//   register, from which its result is taken with rsp_ready.
//   throughput: one request per cycle unless the result stage stalls; the priority
//   search over both 256-bit maps and the map update settle in the single stage
//   between the two registers, so each request sees all earlier updates.
//   stall: while a result waits on rsp_ready the result stage holds, the maps
//   do not change, and req_ready stays high only until the input register fills.
//   reset (synchronous, active high): both maps clear, so the first allocate
//   returns id 1; both register stages empty.
`timescale 1ns / 1ps
`default_nettype none
`include "reusable_id_allocator_unit_macros.svh"

module reusable_id_allocator_unit (
   input  var logic             clock,
   input  var logic             reset,
   input  var logic             req_valid,
   output logic                 req_ready,
   input  var ria_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  var logic             rsp_ready,
   output ria_pkg::rsp_type     rsp_data
);

   logic                in_valid_ff;
   ria_pkg::req_type    in_ff;
   logic                rsp_valid_ff;
   ria_pkg::rsp_type    rsp_ff;
   ria_pkg::rsp_type    rsp_in;
   ria_pkg::map_type    assigned_ff;
   ria_pkg::map_type    assigned_in;
   ria_pkg::map_type    freed_ff;
   ria_pkg::map_type    freed_in;
   ria_pkg::search_type search;
   ria_pkg::op_type     op;
   ria_pkg::id_type     rid;
   logic                advance;
   logic                fire;
   logic                rid_bad;

   ria_find u_find (
      .freed_map    (freed_ff),
      .assigned_map (assigned_ff),
      .search       (search)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign op      = ria_pkg::op_type'(in_ff.operation);
   assign rid     = in_ff.request_id;
   assign rid_bad = (rid == '0) || (int'(rid) > ria_pkg::SPACE_TOP);

   always_comb begin
      assigned_in       = assigned_ff;
      freed_in          = freed_ff;
      rsp_in.granted_id = '0;
      rsp_in.status     = ria_pkg::ST_OK;
      unique case (op)
         ria_pkg::OP_ALLOC: begin
            if (search.free_found) begin
               assigned_in[search.free_low] = 1'b1;
               freed_in[search.free_low]    = 1'b0;
               rsp_in.granted_id            = search.free_low;
            end else if (search.top_found &&
                         (int'(search.top_high) >= ria_pkg::SPACE_TOP)) begin
               rsp_in.status = ria_pkg::ST_EXHAUSTED;
            end else begin
               assigned_in[search.top_high + 1'b1] = 1'b1;
               freed_in[search.top_high + 1'b1]    = 1'b0;
               rsp_in.granted_id                   = search.top_high + 1'b1;
            end
         end
         ria_pkg::OP_CLAIM: begin
            if (rid_bad) begin
               rsp_in.status = ria_pkg::ST_INVALID;
            end else if (assigned_ff[rid]) begin
               rsp_in.status = ria_pkg::ST_TAKEN;
            end else begin
               assigned_in[rid]  = 1'b1;
               freed_in[rid]     = 1'b0;
               rsp_in.granted_id = rid;
            end
         end
         ria_pkg::OP_RELEASE: begin
            if (!rid_bad) begin
               assigned_in[rid] = 1'b0;
               freed_in[rid]    = 1'b1;
            end
         end
         ria_pkg::OP_NONE: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         assigned_ff  <= '0;
         freed_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            assigned_ff <= assigned_in;
            freed_ff    <= freed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // an id is never both assigned and freed, and id zero is never tracked
   `RIA_ASSERT_NOW(a_maps_disjoint, clock, reset, 1'b1, (assigned_ff & freed_ff) == '0)
   `RIA_ASSERT_NOW(a_zero_untracked, clock, reset, 1'b1, !assigned_ff[0] && !freed_ff[0])
   // a granted id is held in the assigned map while its result is shown
   `RIA_ASSERT_NOW(a_grant_assigned, clock, reset, rsp_valid_ff && (rsp_ff.granted_id != '0), assigned_ff[rsp_ff.granted_id])
   // maps stay frozen while the result stage is stalled
   `RIA_ASSERT_NEXT(a_stall_frozen, clock, reset, rsp_valid_ff && !rsp_ready, $stable(assigned_ff) && $stable(freed_ff))

endmodule

`default_nettype wire
